// ===== rtl/core/slc8fr_pkg.sv =====
// shared types, constants and the crc-8 step for the frame receiver
// no dependencies
`timescale 1ns / 1ps

package slc8fr_pkg;

    localparam logic [7:0] SyncReset  = 8'hA5;
    localparam logic [7:0] MaxLenReset = 8'd250;
    localparam logic [7:0] LenCap     = 8'd252;
    localparam logic [7:0] CrcPoly    = 8'h07;
    localparam logic [7:0] CrcInit    = 8'hFF;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic CfgSync   = 1'b0;
    localparam logic CfgMaxLen = 1'b1;

    localparam logic [2:0] PhHunt    = 3'd0;
    localparam logic [2:0] PhLenHi   = 3'd1;
    localparam logic [2:0] PhLenLo   = 3'd2;
    localparam logic [2:0] PhPayload = 3'd3;
    localparam logic [2:0] PhCrc     = 3'd4;

    // one classified beat handed from the front to the back
    typedef struct packed {
        logic       is_end;
        logic       first;
        logic [7:0] data;
        logic [7:0] length;
    } t_op;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CrcPoly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/sync_length_crc8_frame_receiver.sv =====
// top level of the sync / length / payload / crc-8 frame receiver
// depends on slc8fr_pkg, slc8fr_front, slc8fr_queue, slc8fr_back
`timescale 1ns / 1ps

// usage
// s_axis carries one received serial byte per beat in tdata[7:0].
// m_axis gives one beat per payload byte (tuser high, byte in tdata[7:0])
// and one beat per frame end (tlast high, crc_ok in tdata[8],
// payload length in tdata[16:9]). header and length bytes give no beat.
// a new byte is taken every cycle while the four-entry queue between the
// parser and the crc stage has room; throughput is one byte per cycle.
// each beat is registered first in the queue and then in the crc/output
// stage before it leaves as an output beat.
// when m_axis_tready is low the output register holds its beat, the queue
// fills, and s_axis_tready drops once the queue is full.
// the cfg port writes sync_value (index 0) and max_payload_len (index 1);
// write only while the block is idle.
// synchronous reset clears the parser to hunting, empties the queue and
// the output register, and loads sync 0xa5 and length limit 250.

module sync_length_crc8_frame_receiver import slc8fr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [8] crc_ok, [16:9] frame_length
    output logic        m_axis_tuser,   // [0] is_payload
    output logic        m_axis_tlast
);

    logic q_full, q_push, q_pop, q_valid;
    t_op  push_op, pop_op;

    slc8fr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_op        (push_op)
    );

    slc8fr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (pop_op)
    );

    slc8fr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (pop_op),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

// ===== rtl/core/slc8fr_front.sv =====
// front: config registers, frame parser, pushes payload and end beats
// depends on slc8fr_pkg
`timescale 1ns / 1ps

module slc8fr_front import slc8fr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_q_full,
    output logic       o_push,
    output t_op        o_op
);

    logic [7:0] r_sync, r_max_len;
    logic [2:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic [7:0] r_plen, n_plen;
    logic [7:0] r_seen, n_seen;
    logic       r_first, n_first;
    logic [7:0] limit;
    logic [7:0] seen_inc;
    logic       accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign limit    = (r_max_len > LenCap) ? LenCap : r_max_len;
    assign seen_inc = r_seen + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SyncReset;
            r_max_len <= MaxLenReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CfgSync:   r_sync    <= i_cfg_wdata;
                CfgMaxLen: r_max_len <= i_cfg_wdata;
                default:   r_sync    <= r_sync;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_plen  = r_plen;
        n_seen  = r_seen;
        n_first = r_first;
        o_push  = 1'b0;
        o_op    = '{is_end: 1'b0, first: r_first, data: i_byte, length: r_plen};
        if (accept) begin
            case (r_phase)
                PhLenHi: begin
                    n_held  = i_byte;
                    n_phase = PhLenLo;
                end
                PhLenLo: begin
                    if (r_held == 8'd0 && i_byte <= limit) begin
                        n_plen  = i_byte;
                        n_seen  = 8'd0;
                        n_first = 1'b1;
                        n_phase = (i_byte == 8'd0) ? PhCrc : PhPayload;
                    end else if (r_held == r_sync) begin
                        n_held = i_byte;
                    end else if (i_byte == r_sync) begin
                        n_phase = PhLenHi;
                    end else begin
                        n_phase = PhHunt;
                    end
                end
                PhPayload: begin
                    o_push  = 1'b1;
                    n_first = 1'b0;
                    n_seen  = seen_inc;
                    if (seen_inc >= r_plen) begin
                        n_phase = PhCrc;
                    end
                end
                PhCrc: begin
                    o_push    = 1'b1;
                    o_op.is_end = 1'b1;
                    n_first   = 1'b0;
                    n_phase   = PhHunt;
                end
                default: begin
                    n_phase = (i_byte == r_sync) ? PhLenHi : PhHunt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhHunt;
            r_held  <= 8'd0;
            r_plen  <= 8'd0;
            r_seen  <= 8'd0;
            r_first <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_plen  <= n_plen;
            r_seen  <= n_seen;
            r_first <= n_first;
        end
    end

endmodule

// ===== rtl/core/slc8fr_queue.sv =====
// short register queue between the parser and the crc back end
// depends on slc8fr_pkg
`timescale 1ns / 1ps

module slc8fr_queue import slc8fr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op              r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [QCntW-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QCntW'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPtrW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCntW'(1);
                2'b01:   r_cnt <= r_cnt - QCntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/slc8fr_back.sv =====
// back: running crc, end-of-frame check and the output register
// depends on slc8fr_pkg
`timescale 1ns / 1ps

module slc8fr_back import slc8fr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_op         i_op,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_data,
    output logic        o_user,
    output logic        o_last
);

    logic [7:0] r_crc;
    logic       r_valid;
    logic [7:0] r_byte, r_len;
    logic       r_ok, r_user, r_last;
    logic [7:0] base;

    assign o_pop = i_q_valid && (!r_valid || i_ready);
    assign base  = i_op.first ? CrcInit : r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_crc   <= CrcInit;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (!i_op.is_end) begin
                    r_crc <= crc8_step(base, i_op.data);
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_user <= !i_op.is_end;
            r_last <= i_op.is_end;
            r_byte <= i_op.is_end ? 8'd0 : i_op.data;
            r_ok   <= i_op.is_end && (i_op.data == base);
            r_len  <= i_op.is_end ? i_op.length : 8'd0;
        end
    end

    assign o_valid = r_valid;
    assign o_user  = r_user;
    assign o_last  = r_last;
    assign o_data  = {7'd0, r_len, r_ok, r_byte};

endmodule

// ===== bench/slc8fr_frame_checker.sv =====
// checker for the frame receiver: watches the config port and both streams,
// predicts each output beat and compares it field by field
// depends on slc8fr_pkg
`timescale 1ns / 1ps

module slc8fr_frame_checker import slc8fr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_data,    // [7:0] rx_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,   // [7:0] out_byte, [8] crc_ok, [16:9] frame_length
    input  logic        i_out_user,   // [0] is_payload
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_payload_beats,
    output int          o_frame_ends,
    output int          o_good_ends
);

    typedef struct packed {
        logic [7:0] data;
        logic       is_payload;
        logic       is_end;
        logic       crc_ok;
        logic [7:0] length;
    } t_frame_beat;

    t_frame_beat awaited_beats[$];

    logic [2:0] rx_phase;
    logic [7:0] sync_byte;
    logic [7:0] len_limit;
    logic [7:0] len_high_hold;
    logic [7:0] frame_len;
    logic [7:0] bytes_taken;
    logic [7:0] crc_acc;

    int mismatches    = 0;
    int beats_checked = 0;
    int payload_beats = 0;
    int frame_ends    = 0;
    int good_ends     = 0;

    // msb-first crc-8 over one byte, no final xor
    function automatic logic [7:0] crc_next(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CrcPoly : 8'h00);
        return r;
    endfunction

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch on output beat %0d: %s is %0h, expected %0h",
                     beats_checked, field, got, want);
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        logic [7:0]  limit;
        t_frame_beat beat;
        bit          has_beat;
        limit    = (len_limit > LenCap) ? LenCap : len_limit;
        beat     = '0;
        has_beat = 1'b0;
        case (rx_phase)
            PhLenHi: begin
                len_high_hold = b;
                rx_phase      = PhLenLo;
            end
            PhLenLo: begin
                if (len_high_hold == 8'h00 && b <= limit) begin
                    frame_len   = b;
                    bytes_taken = 8'h00;
                    crc_acc     = CrcInit;
                    rx_phase    = (b == 8'h00) ? PhCrc : PhPayload;
                end else if (len_high_hold == sync_byte) begin
                    // held high byte reopens a frame, this byte is its new high byte
                    len_high_hold = b;
                end else if (b == sync_byte) begin
                    rx_phase = PhLenHi;
                end else begin
                    rx_phase = PhHunt;
                end
            end
            PhPayload: begin
                crc_acc     = crc_next(crc_acc, b);
                bytes_taken = bytes_taken + 8'd1;
                if (bytes_taken >= frame_len) rx_phase = PhCrc;
                beat.data       = b;
                beat.is_payload = 1'b1;
                has_beat        = 1'b1;
            end
            PhCrc: begin
                beat.is_end = 1'b1;
                beat.crc_ok = (b == crc_acc);
                beat.length = frame_len;
                rx_phase    = PhHunt;
                has_beat    = 1'b1;
            end
            default: begin
                rx_phase = (b == sync_byte) ? PhLenHi : PhHunt;
            end
        endcase
        if (has_beat) awaited_beats.push_back(beat);
    endtask

    task automatic check_out_beat();
        t_frame_beat want;
        if (awaited_beats.size() == 0) begin
            report("unexpected beat, byte", i_out_data[7:0], 8'h00);
        end else begin
            want = awaited_beats.pop_front();
            if (i_out_data[7:0] !== want.data) report("out_byte", i_out_data[7:0], want.data);
            if (i_out_user !== want.is_payload) begin
                report("is_payload", {7'd0, i_out_user}, {7'd0, want.is_payload});
            end
            if (i_out_last !== want.is_end) begin
                report("is_end", {7'd0, i_out_last}, {7'd0, want.is_end});
            end
            if (i_out_data[8] !== want.crc_ok) begin
                report("crc_ok", {7'd0, i_out_data[8]}, {7'd0, want.crc_ok});
            end
            if (i_out_data[16:9] !== want.length) begin
                report("frame_length", i_out_data[16:9], want.length);
            end
            if (want.is_payload) payload_beats++;
            if (want.is_end) begin
                frame_ends++;
                if (want.crc_ok) good_ends++;
            end
        end
        beats_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_beats.delete();
            rx_phase      = PhHunt;
            sync_byte     = SyncReset;
            len_limit     = MaxLenReset;
            len_high_hold = 8'h00;
            frame_len     = 8'h00;
            bytes_taken   = 8'h00;
            crc_acc       = CrcInit;
        end else begin
            if (i_out_valid && i_out_ready) check_out_beat();
            if (i_cfg_we) begin
                if (i_cfg_addr == CfgSync) begin
                    sync_byte = i_cfg_wdata;
                end else begin
                    len_limit = i_cfg_wdata;
                end
            end
            if (i_rx_valid && i_rx_ready) take_rx_byte(i_rx_data);
        end
        o_errors        <= mismatches;
        o_pending       <= awaited_beats.size();
        o_payload_beats <= payload_beats;
        o_frame_ends    <= frame_ends;
        o_good_ends     <= good_ends;
    end

endmodule

// ===== bench/tb_sync_length_crc8_frame_receiver.sv =====
// testbench top for the frame receiver: clock, reset, byte stimulus,
// output back-pressure, watchdog and verdict
// depends on slc8fr_pkg, sync_length_crc8_frame_receiver, slc8fr_frame_checker
`timescale 1ns / 1ps

module tb_sync_length_crc8_frame_receiver import slc8fr_pkg::*;;

    localparam int StallLimit = 3000;
    localparam int HoldCycles = 300;
    localparam int PhaseBeats = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] out_byte, [8] crc_ok, [16:9] frame_length
    logic        m_axis_tuser;            // [0] is_payload
    logic        m_axis_tlast;

    int errors, pending, payload_beats, frame_ends, good_ends;

    int         beats_sent      = 0;
    int         settings_used   = 1;
    int         holds_requested = 0;
    int         holds_served    = 0;
    int         quiet_cycles    = 0;
    bit         tx_burst        = 1'b0;
    bit         rx_burst        = 1'b0;
    logic [7:0] sync_cur        = SyncReset;
    logic [7:0] max_cur         = MaxLenReset;

    always #6 i_clk = ~i_clk;

    sync_length_crc8_frame_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    slc8fr_frame_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_valid      (s_axis_tvalid),
        .i_rx_ready      (s_axis_tready),
        .i_rx_data       (s_axis_tdata),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .i_out_last      (m_axis_tlast),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_payload_beats (payload_beats),
        .o_frame_ends    (frame_ends),
        .o_good_ends     (good_ends)
    );

    function automatic logic [7:0] crc_fold(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CrcPoly) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] len_cap();
        return (max_cur > LenCap) ? LenCap : max_cur;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
        if (beats_sent % 64 == 0) tx_burst = ($urandom_range(0, 2) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // fill below zero gives random payload, else alternating fill and its inverse
    task automatic push_frame(input int len, input bit bad_crc, input int fill);
        logic [7:0] crc;
        logic [7:0] b;
        crc = CrcInit;
        send_byte(sync_cur);
        send_byte(8'h00);
        send_byte(len[7:0]);
        for (int i = 0; i < len; i++) begin
            if (fill < 0) begin
                b = 8'($urandom_range(0, 255));
            end else if (i % 2 == 1) begin
                b = ~fill[7:0];
            end else begin
                b = fill[7:0];
            end
            crc = crc_fold(crc, b);
            send_byte(b);
        end
        if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
        send_byte(crc);
    endtask

    task automatic random_chunk();
        int         pick;
        int         len;
        logic [7:0] lim;
        lim  = len_cap();
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0) begin
            len = $urandom_range(0, lim);
        end else begin
            len = $urandom_range(0, (lim < 12) ? lim : 12);
        end
        if (pick < 70) begin
            push_frame(len, $urandom_range(0, 6) == 0, -1);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_byte(sync_cur);
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end else if (pick < 88) begin
            // oversize length
            send_byte(sync_cur);
            if ($urandom_range(0, 1) == 1) begin
                send_byte(8'($urandom_range(1, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'h00);
                send_byte(8'($urandom_range(lim + 1, 255)));
            end
        end else if (pick < 94) begin
            // sync byte standing in the length high position
            send_byte(sync_cur);
            push_frame(len, 1'b0, -1);
        end else begin
            send_byte(sync_cur);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sync_val, input logic [7:0] max_len);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CfgSync;
        i_cfg_wdata <= sync_val;
        @(posedge i_clk);
        i_cfg_addr  <= CfgMaxLen;
        i_cfg_wdata <= max_len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sync_cur = sync_val;
        max_cur  = max_len;
        settings_used++;
    endtask

    // output side back-pressure
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_served != holds_requested) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 14);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) rx_burst = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("timeout: no beat moved for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int target;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: noise, payload extremes, bad crc, oversize lengths, zero length
        send_byte(8'h00);
        push_frame(2, 1'b0, 0);
        push_frame(1, 1'b1, 8'h5A);
        send_byte(sync_cur);
        send_byte(8'h01);
        push_frame(1, 1'b0, -1);
        send_byte(sync_cur);
        send_byte(8'h00);
        send_byte(8'hFB);
        send_byte(sync_cur);
        push_frame(0, 1'b0, -1);

        holds_requested++;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                // leave the parser waiting for a length low byte across the write
                send_byte(sync_cur);
                send_byte(8'h00);
                wait_idle();
                case (ph)
                    1: set_config(8'h00, 8'd0);
                    2: set_config(8'hFF, 8'hFF);
                    3: set_config(8'h7E, LenCap);
                    4: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 20)));
                    default: set_config(SyncReset, MaxLenReset);
                endcase
            end
            if (ph == 2) begin
                holds_requested++;
                push_frame(len_cap(), 1'b0, -1);
            end
            target = beats_sent + PhaseBeats;
            while (beats_sent < target) random_chunk();
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("run covered %0d input beats under %0d register settings, %0d long output stalls",
                 beats_sent, settings_used, holds_served);
        $display("checked %0d payload beats and %0d frame ends, %0d of them with a good crc",
                 payload_beats, frame_ends, good_ends);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slc8fr_pkg.sv
rtl/core/slc8fr_front.sv
rtl/core/slc8fr_queue.sv
rtl/core/slc8fr_back.sv
rtl/core/sync_length_crc8_frame_receiver.sv
bench/slc8fr_frame_checker.sv
bench/tb_sync_length_crc8_frame_receiver.sv
